### rtl/core/window_min_filter_defines.svh
`ifndef WINDOW_MIN_FILTER_DEFINES_SVH
`define WINDOW_MIN_FILTER_DEFINES_SVH

// Concurrent check sampled on the rising clock edge and held off during reset.
`define WMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define WMF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/core/wmf_pkg.sv
package wmf_pkg;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_OUT_W  = 11;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned RAD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Column queue between the front and the back end.
  localparam int unsigned PTR_W       = 2;
  localparam int unsigned QUEUE_DEPTH = 2 ** PTR_W;
  localparam int unsigned LEVEL_W     = PTR_W + 1;

  localparam logic [7:0]          CHAN_MAX   = 8'hFF;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  localparam pixel_t PIXEL_MAX = '{red: CHAN_MAX, green: CHAN_MAX, blue: CHAN_MAX};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_ROWS  = 3'd0,
    CFG_RADIUS_COLS  = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_COLOR_MODE   = 3'd4
  } cfg_idx_e;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [RAD_W-1:0]    rad_rows;
    logic [RAD_W-1:0]    rad_cols;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                color;
  } cfg_t;

  typedef struct packed {
    logic                 emit;
    logic                 frame_end;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } tag_t;

  // One image column slice: vertical minimum over the window rows, with and
  // without the center row.
  typedef struct packed {
    tag_t   tag;
    pixel_t full_min;
    pixel_t part_min;
  } col_item_t;

  typedef struct packed {
    pixel_t               mins;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 frame_end;
  } res_t;

  function automatic pixel_t pixel_min(pixel_t a, pixel_t b);
    pixel_t m;
    m.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
    m.green = (a.green < b.green) ? a.green : b.green;
    m.red   = (a.red   < b.red)   ? a.red   : b.red;
    return m;
  endfunction

endpackage

### rtl/core/window_min_filter.sv
// Streaming 2-D minimum filter with the center pixel left out of the window.
// Input channel: pixels in raster order, one item per push, accepted on a
// rising clock edge with push high and full low. In gray mode only
// pixel_blue_i is used. Result channel: while empty is low the oldest result
// sits on the result ports and it leaves on an edge with pop high.
// A result is produced for each pixel whose whole window lies inside the
// frame, once the last pixel of that window has been pushed; border pixels
// produce nothing. It carries the center coordinates and marks the last
// result of the frame with frame_end_o.
// Throughput is one item per clock while full stays low. A result passes through the
// line memory read, the column minimum, the column queue, the column shift
// register and the row minimum into the output register before it appears
// on the ports.
// Reset loads the register defaults, clears the raster position and empties
// the pipeline; the line memory is not cleared, since each window only reads
// rows written in the current frame. When pop stays low the result is held,
// the back end freezes, the four-entry column queue takes the pixels still in
// flight and full rises so the input stalls without losing an item.
// Any write to a listed configuration register restarts the frame; writes
// are expected only while the block is idle.
module window_min_filter #(
  parameter int unsigned MAX_RADIUS = 3,
  parameter int unsigned MAX_WIDTH  = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         pixel_blue_i,
  input  logic [7:0]                         pixel_green_i,
  input  logic [7:0]                         pixel_red_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [7:0]                         min_blue_o,
  output logic [7:0]                         min_green_o,
  output logic [7:0]                         min_red_o,
  output logic [wmf_pkg::ROW_W-1:0]          out_row_o,
  output logic [wmf_pkg::COL_OUT_W-1:0]      out_col_o,
  output logic                               frame_end_o,
  input  logic                               cfg_we_i,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Configuration registers as written.
  logic [wmf_pkg::RAD_W-1:0]    rad_rows_q;
  logic [wmf_pkg::RAD_W-1:0]    rad_cols_q;
  logic [wmf_pkg::WIDTH_W-1:0]  width_q;
  logic [wmf_pkg::HEIGHT_W-1:0] height_q;
  logic                         color_q;
  logic                         cfg_restart;

  wmf_pkg::cfg_t               cfg;
  wmf_pkg::pixel_t             pixel_in;
  logic                        accept;
  logic                        col_valid;
  wmf_pkg::col_item_t          col_item;
  logic                        q_valid;
  logic                        q_pop;
  wmf_pkg::col_item_t          q_item;
  logic [wmf_pkg::LEVEL_W-1:0] q_level;
  logic                        res_valid;
  wmf_pkg::res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_rows_q <= 2'd1;
      rad_cols_q <= 2'd1;
      width_q    <= 12'd640;
      height_q   <= 13'd480;
      color_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (wmf_pkg::cfg_idx_e'(cfg_idx_i))
        wmf_pkg::CFG_RADIUS_ROWS:  rad_rows_q <= cfg_data_i[1:0];
        wmf_pkg::CFG_RADIUS_COLS:  rad_cols_q <= cfg_data_i[1:0];
        wmf_pkg::CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i[11:0];
        wmf_pkg::CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i[12:0];
        wmf_pkg::CFG_COLOR_MODE:   color_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A write to any listed register starts a new frame.
  always_comb begin
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      case (wmf_pkg::cfg_idx_e'(cfg_idx_i))
        wmf_pkg::CFG_RADIUS_ROWS,
        wmf_pkg::CFG_RADIUS_COLS,
        wmf_pkg::CFG_IMAGE_WIDTH,
        wmf_pkg::CFG_IMAGE_HEIGHT,
        wmf_pkg::CFG_COLOR_MODE: cfg_restart = 1'b1;
        default:                 cfg_restart = 1'b0;
      endcase
    end
  end

  // Clamp the registers to what the hardware supports.
  always_comb begin
    cfg.rad_rows = (int'(rad_rows_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : rad_rows_q;
    cfg.rad_cols = (int'(rad_cols_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : rad_cols_q;
    if (width_q == '0) begin
      cfg.width = 12'd1;
    end else if (int'(width_q) > MAX_WIDTH) begin
      cfg.width = 12'(MAX_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == '0) begin
      cfg.height = 13'd1;
    end else if (height_q > wmf_pkg::MAX_HEIGHT) begin
      cfg.height = wmf_pkg::MAX_HEIGHT;
    end else begin
      cfg.height = height_q;
    end
    cfg.color = color_q;
  end

  assign pixel_in.blue  = pixel_blue_i;
  assign pixel_in.green = pixel_green_i;
  assign pixel_in.red   = pixel_red_i;
  assign accept         = push && !full;

  wmf_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .restart_i   (cfg_restart),
    .accept_i    (accept),
    .pixel_i     (pixel_in),
    .q_level_i   (q_level),
    .full_o      (full),
    .col_valid_o (col_valid),
    .col_item_o  (col_item)
  );

  wmf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (col_valid),
    .item_i  (col_item),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid),
    .level_o (q_level)
  );

  wmf_back #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rad_cols_i  (cfg.rad_cols),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Green and red read as zero in gray mode.
  assign empty       = !res_valid;
  assign min_blue_o  = res.mins.blue;
  assign min_green_o = color_q ? res.mins.green : 8'd0;
  assign min_red_o   = color_q ? res.mins.red   : 8'd0;
  assign out_row_o   = res.row;
  assign out_col_o   = res.col;
  assign frame_end_o = res.frame_end;

endmodule

### rtl/core/wmf_front.sv
module wmf_front #(
  parameter int unsigned MAX_RADIUS = 3,
  parameter int unsigned MAX_WIDTH  = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wmf_pkg::cfg_t                   cfg_i,
  input  logic                            restart_i,
  input  logic                            accept_i,
  input  wmf_pkg::pixel_t                 pixel_i,
  input  logic [wmf_pkg::LEVEL_W-1:0]     q_level_i,
  output logic                            full_o,
  output logic                            col_valid_o,
  output wmf_pkg::col_item_t              col_item_o
);

  localparam int unsigned HIST_N  = 2 * MAX_RADIUS;
  localparam int unsigned STACK_N = HIST_N + 1;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned SUM_W   = wmf_pkg::LEVEL_W + 1;

  // Each line memory word holds the previous rows of one column, newest first.
  wmf_pkg::pixel_t [HIST_N-1:0] line_mem_q [MAX_WIDTH];
  wmf_pkg::pixel_t [HIST_N-1:0] rd_hist_q;
  wmf_pkg::pixel_t [HIST_N-1:0] hist_cur;

  logic [wmf_pkg::ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic                      last_col, last_row;
  logic [COL_W-1:0]          col_diff;
  wmf_pkg::tag_t             tag_in;
  wmf_pkg::pixel_t           pix_in;

  logic                          f1_valid_q;
  wmf_pkg::pixel_t               f1_pix_q;
  wmf_pkg::tag_t                 f1_tag_q;
  logic [COL_W-1:0]              f1_col_q;

  logic                          f2_valid_q;
  wmf_pkg::pixel_t [STACK_N-1:0] f2_stack_q;
  wmf_pkg::tag_t                 f2_tag_q;
  logic [COL_W-1:0]              f2_col_q;

  wmf_pkg::pixel_t full_min, part_min;
  logic [SUM_W-1:0] used_slots;

  // Raster position and classification of the incoming pixel.
  always_comb begin
    last_col = (13'(col_q) + 13'd1) >= 13'(cfg_i.width);
    last_row = (13'(row_q) + 13'd1) >= cfg_i.height;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 12'd1;
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
    col_diff         = col_q - COL_W'(cfg_i.rad_cols);
    tag_in.emit      = (row_q >= 12'({cfg_i.rad_rows, 1'b0})) &&
                       (col_q >= COL_W'({cfg_i.rad_cols, 1'b0}));
    tag_in.frame_end = last_col && last_row;
    tag_in.row       = row_q - 12'(cfg_i.rad_rows);
    tag_in.col       = 11'(col_diff);
    pix_in           = pixel_i;
    if (!cfg_i.color) begin
      pix_in.green = '0;
      pix_in.red   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      if (restart_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept_i) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      f1_valid_q <= accept_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  // The item that wrote last cycle may have hit the same column (one pixel
  // wide images), so its write data takes precedence over the memory read.
  assign hist_cur = (f2_valid_q && (f2_col_q == f1_col_q)) ?
                    f2_stack_q[HIST_N-1:0] : rd_hist_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_hist_q <= line_mem_q[col_q];
      f1_pix_q  <= pix_in;
      f1_tag_q  <= tag_in;
      f1_col_q  <= col_q;
    end
    if (f1_valid_q) begin
      line_mem_q[f1_col_q] <= {hist_cur[HIST_N-2:0], f1_pix_q};
      f2_stack_q           <= {hist_cur, f1_pix_q};
      f2_tag_q             <= f1_tag_q;
      f2_col_q             <= f1_col_q;
    end
  end

  // Vertical minimum over the window rows of this column.
  always_comb begin
    full_min = wmf_pkg::PIXEL_MAX;
    part_min = wmf_pkg::PIXEL_MAX;
    for (int k = 0; k < STACK_N; k++) begin
      if (k <= 2 * int'(cfg_i.rad_rows)) begin
        full_min = wmf_pkg::pixel_min(full_min, f2_stack_q[k]);
        if (k != int'(cfg_i.rad_rows)) begin
          part_min = wmf_pkg::pixel_min(part_min, f2_stack_q[k]);
        end
      end
    end
  end

  assign col_valid_o         = f2_valid_q;
  assign col_item_o.tag      = f2_tag_q;
  assign col_item_o.full_min = full_min;
  assign col_item_o.part_min = part_min;

  // Items in flight always have a queue slot reserved.
  assign used_slots = SUM_W'(q_level_i) + SUM_W'(f1_valid_q) + SUM_W'(f2_valid_q);
  assign full_o     = used_slots >= SUM_W'(wmf_pkg::QUEUE_DEPTH);

endmodule

### rtl/core/wmf_queue.sv
module wmf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  wmf_pkg::col_item_t          item_i,
  input  logic                        pop_i,
  output wmf_pkg::col_item_t          item_o,
  output logic                        valid_o,
  output logic [wmf_pkg::LEVEL_W-1:0] level_o
);

  wmf_pkg::col_item_t entry_q [wmf_pkg::QUEUE_DEPTH];

  logic [wmf_pkg::PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wmf_pkg::LEVEL_W-1:0] level_q, level_d;

  assign level_d = level_q + wmf_pkg::LEVEL_W'(push_i) - wmf_pkg::LEVEL_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + wmf_pkg::PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + wmf_pkg::PTR_W'(1);
      end
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = entry_q[rd_ptr_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

endmodule

### rtl/core/wmf_back.sv
module wmf_back #(
  parameter int unsigned MAX_RADIUS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wmf_pkg::RAD_W-1:0]     rad_cols_i,
  input  logic                          q_valid_i,
  input  wmf_pkg::col_item_t            q_item_i,
  output logic                          q_pop_o,
  input  logic                          res_pop_i,
  output logic                          res_valid_o,
  output wmf_pkg::res_t                 res_o
);

  localparam int unsigned STACK_N = 2 * MAX_RADIUS + 1;

  // Column minima of the most recent columns, newest at index zero.
  wmf_pkg::pixel_t full_sr_q [STACK_N];
  wmf_pkg::pixel_t part_sr_q [STACK_N];

  logic            a_valid_q;
  wmf_pkg::tag_t   a_tag_q;
  logic            b_valid_q;
  wmf_pkg::res_t   b_res_q;
  logic            a_ready, b_ready;
  wmf_pkg::pixel_t win_min;

  assign b_ready = !b_valid_q || res_pop_i;
  assign a_ready = !a_valid_q || b_ready;
  assign q_pop_o = q_valid_i && a_ready;

  // Horizontal minimum; the center column contributes its minimum without
  // the center pixel.
  always_comb begin
    win_min = wmf_pkg::PIXEL_MAX;
    for (int k = 0; k < STACK_N; k++) begin
      if (k <= 2 * int'(rad_cols_i)) begin
        if (k == int'(rad_cols_i)) begin
          win_min = wmf_pkg::pixel_min(win_min, part_sr_q[k]);
        end else begin
          win_min = wmf_pkg::pixel_min(win_min, full_sr_q[k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= q_pop_o && q_item_i.tag.emit;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      full_sr_q[0] <= q_item_i.full_min;
      part_sr_q[0] <= q_item_i.part_min;
      for (int k = 1; k < STACK_N; k++) begin
        full_sr_q[k] <= full_sr_q[k-1];
        part_sr_q[k] <= part_sr_q[k-1];
      end
      a_tag_q <= q_item_i.tag;
    end
    if (b_ready && a_valid_q) begin
      b_res_q.mins      <= win_min;
      b_res_q.row       <= a_tag_q.row;
      b_res_q.col       <= a_tag_q.col;
      b_res_q.frame_end <= a_tag_q.frame_end;
    end
  end

  assign res_valid_o = b_valid_q;
  assign res_o       = b_res_q;

endmodule

### rtl/core/wmf_checker.sv
`include "window_min_filter_defines.svh"

module wmf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           cfg_we_i,
  input logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic [7:0]                     min_blue_i,
  input logic [7:0]                     min_green_i,
  input logic [7:0]                     min_red_i,
  input logic [wmf_pkg::ROW_W-1:0]      out_row_i,
  input logic [wmf_pkg::COL_OUT_W-1:0]  out_col_i,
  input logic                           frame_end_i
);

  // Mirror of the color mode register, seen through the write port.
  logic mode_q, mode_d;

  assign mode_d = (cfg_we_i && (cfg_idx_i == wmf_pkg::CFG_COLOR_MODE)) ?
                  cfg_data_i[0] : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
    end
  end

  `WMF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(min_blue_i) && $stable(out_row_i) && $stable(out_col_i) && $stable(frame_end_i), "waiting result changed")

  `WMF_ASSERT_NEXT(a_full_needs_push, !(push && !full), !$rose(full), "full rose with no item taken")

  `WMF_ASSERT(a_gray_zero, !empty && !mode_q |-> min_green_i == 8'd0 && min_red_i == 8'd0, "color minimum in gray mode")

endmodule

bind window_min_filter wmf_checker u_wmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .min_blue_i  (min_blue_o),
  .min_green_i (min_green_o),
  .min_red_i   (min_red_o),
  .out_row_i   (out_row_o),
  .out_col_i   (out_col_o),
  .frame_end_i (frame_end_o)
);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Self-checking bench for the streaming minimum filter.
  //
  // A stimulus queue is filled at time zero with pixel items, register writes and a few
  // control entries (idle phase changes, a pause until the result stream has drained,
  // requests for a long receiver stall). A clocked driver works through that queue. A
  // clocked monitor watches both sides of the block. Every accepted pixel goes through a
  // local model of the filter, which pushes the expected result, if any, into a queue.
  // Every popped result is compared field by field with the oldest entry of that queue.

  localparam int unsigned RADIUS_LIMIT = 3;
  localparam int unsigned WIDTH_LIMIT  = 2048;
  localparam int unsigned RING_ROWS    = 2 * RADIUS_LIMIT + 1;

  localparam int unsigned RESET_CYCLES = 12;
  // A quiet count of QUIET_CYCLES, with no traffic and no pending results, means that the
  // pipeline is empty.
  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned END_QUIET    = 16;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned TIMEOUT_NS   = 3_000_000;

  // Index past the end of the register list: the write must change nothing.
  localparam logic [wmf_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef enum {
    OP_PIXEL,
    OP_CONFIG,
    OP_DRAIN,
    OP_PHASE,
    OP_HOLD
  } op_kind_e;

  typedef struct {
    op_kind_e                       kind;
    wmf_pkg::chan_t                 blue;
    wmf_pkg::chan_t                 green;
    wmf_pkg::chan_t                 red;
    logic [wmf_pkg::CFG_IDX_W-1:0]  idx;
    logic [wmf_pkg::CFG_DATA_W-1:0] data;
    int unsigned                    send_idle;
    int unsigned                    recv_idle;
  } raster_op_t;

  typedef struct packed {
    wmf_pkg::chan_t                blue;
    wmf_pkg::chan_t                green;
    wmf_pkg::chan_t                red;
    logic [wmf_pkg::ROW_W-1:0]     row;
    logic [wmf_pkg::COL_OUT_W-1:0] col;
    logic                          frame_end;
  } window_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           push;
  logic                           full;
  wmf_pkg::chan_t                 pixel_blue_i;
  wmf_pkg::chan_t                 pixel_green_i;
  wmf_pkg::chan_t                 pixel_red_i;
  logic                           empty;
  logic                           pop;
  wmf_pkg::chan_t                 min_blue_o;
  wmf_pkg::chan_t                 min_green_o;
  wmf_pkg::chan_t                 min_red_o;
  logic [wmf_pkg::ROW_W-1:0]      out_row_o;
  logic [wmf_pkg::COL_OUT_W-1:0]  out_col_o;
  logic                           frame_end_o;
  logic                           cfg_we_i;
  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  window_min_filter #(
    .MAX_RADIUS(RADIUS_LIMIT),
    .MAX_WIDTH (WIDTH_LIMIT)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_blue_i (pixel_blue_i),
    .pixel_green_i(pixel_green_i),
    .pixel_red_i  (pixel_red_i),
    .empty        (empty),
    .pop          (pop),
    .min_blue_o   (min_blue_o),
    .min_green_o  (min_green_o),
    .min_red_o    (min_red_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_end_o  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Stimulus waiting for the driver, and results waiting for the block.
  raster_op_t     raster_ops[$];
  window_result_t expected_mins[$];

  // Shared between the processes. Each one is written by a single process only.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned idle_cycles;
  int unsigned mismatches;

  // The monitor's copy of the registers, the raster position and the line store.
  logic [wmf_pkg::RAD_W-1:0]    rad_rows_q;
  logic [wmf_pkg::RAD_W-1:0]    rad_cols_q;
  logic [wmf_pkg::WIDTH_W-1:0]  width_q;
  logic [wmf_pkg::HEIGHT_W-1:0] height_q;
  logic                         color_q;
  int unsigned                  row_pos;
  int unsigned                  col_pos;
  logic [23:0]                  line_mem[RING_ROWS][WIDTH_LIMIT];

  int unsigned hold_left;
  int unsigned holds_served;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic raster_op_t blank_op(op_kind_e kind);
    raster_op_t op;
    op.kind      = kind;
    op.blue      = '0;
    op.green     = '0;
    op.red       = '0;
    op.idx       = '0;
    op.data      = '0;
    op.send_idle = 0;
    op.recv_idle = 0;
    return op;
  endfunction

  task automatic queue_pixel(input wmf_pkg::chan_t blue, input wmf_pkg::chan_t green,
                             input wmf_pkg::chan_t red);
    raster_op_t op;
    op       = blank_op(OP_PIXEL);
    op.blue  = blue;
    op.green = green;
    op.red   = red;
    raster_ops.push_back(op);
  endtask

  task automatic queue_write(input logic [wmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wmf_pkg::CFG_DATA_W-1:0] data);
    raster_op_t op;
    op      = blank_op(OP_CONFIG);
    op.idx  = idx;
    op.data = data;
    raster_ops.push_back(op);
  endtask

  task automatic queue_control(input op_kind_e kind);
    raster_ops.push_back(blank_op(kind));
  endtask

  task automatic queue_phase(input int unsigned send_idle, input int unsigned recv_idle);
    raster_op_t op;
    op           = blank_op(OP_PHASE);
    op.send_idle = send_idle;
    op.recv_idle = recv_idle;
    raster_ops.push_back(op);
  endtask

  // Writes all five registers. Data bits above each register's width are random, since
  // the block must drop them.
  task automatic queue_setup(input logic [1:0] rr, input logic [1:0] rc,
                             input logic [11:0] w, input logic [12:0] h,
                             input logic color);
    queue_write(wmf_pkg::CFG_RADIUS_ROWS,  {11'($urandom), rr});
    queue_write(wmf_pkg::CFG_RADIUS_COLS,  {11'($urandom), rc});
    queue_write(wmf_pkg::CFG_IMAGE_WIDTH,  {1'($urandom), w});
    queue_write(wmf_pkg::CFG_IMAGE_HEIGHT, h);
    queue_write(wmf_pkg::CFG_COLOR_MODE,   {12'($urandom), color});
  endtask

  // Mostly full-range samples, with the two extremes that decide a minimum more often.
  function automatic wmf_pkg::chan_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_random_pixels(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      queue_pixel(rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  // One random image setting followed by its pixels. Most frames are large enough for the
  // window, are sent whole, and sometimes run on into the next frame. A few are too small
  // for any result or are cut short by the next register write.
  task automatic queue_random_frame(inout int unsigned pixels);
    logic [1:0]  rr;
    logic [1:0]  rc;
    logic [11:0] w;
    logic [12:0] h;
    logic        color;
    int unsigned area;
    int unsigned count;
    int unsigned first;
    rr    = 2'($urandom_range(0, 3));
    rc    = 2'($urandom_range(0, 3));
    color = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      w = 12'($urandom_range(0, 2 * rc));
      h = 13'($urandom_range(0, 6));
    end else begin
      w = 12'($urandom_range(2 * rc + 1, 2 * rc + 8));
      h = 13'($urandom_range(2 * rr + 1, 2 * rr + 6));
    end
    queue_setup(rr, rc, w, h, color);
    area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: count = area;
      6, 7:             count = 2 * area;
      8:                count = area + $urandom_range(1, area);
      default:          count = $urandom_range(1, area);
    endcase
    // Now and then the sender stops halfway and waits for every pending result.
    if ($urandom_range(0, 9) == 0) begin
      first = count / 2;
      queue_random_pixels(first);
      queue_control(OP_DRAIN);
      queue_random_pixels(count - first);
    end else begin
      queue_random_pixels(count);
    end
    pixels += count;
  endtask

  task automatic build_stimulus();
    int unsigned pixels;

    // Phase one: the sender rarely idles, the receiver mostly does.
    queue_phase(21, 82);

    // A 4x4 color frame with a 3x3 window. The one zero blue sample sits at the center
    // of the first window, so that window must not see it while its neighbors do.
    queue_setup(2'd1, 2'd1, 12'd4, 13'd4, 1'b1);
    for (int unsigned k = 0; k < 16; k++) begin
      queue_pixel((k == 5) ? 8'h00 : 8'hFF, (k == 0) ? 8'h00 : 8'hFF,
                  (k == 15) ? 8'h00 : 8'($urandom_range(1, 255)));
    end

    // Gray mode with a window of the center alone: every result is the start value.
    queue_setup(2'd0, 2'd0, 12'd3, 13'd2, 1'b0);
    queue_random_pixels(6);

    // Zero width and height act as a 1x1 image, so each pixel is a whole frame.
    queue_setup(2'd0, 2'd0, 12'd0, 13'd0, 1'b1);
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'h5A, 8'hA5, 8'h3C);

    // Windows taller, then wider, than the image: no results at all.
    queue_setup(2'd3, 2'd0, 12'd2, 13'd3, 1'b1);
    queue_random_pixels(6);
    queue_setup(2'd0, 2'd3, 12'd4, 13'd2, 1'b0);
    queue_random_pixels(8);

    // A frame cut short by a register write, which restarts the raster position. The
    // write to an index past the list lands mid-frame and must not restart it.
    queue_setup(2'd1, 2'd0, 12'd2, 13'd4, 1'b1);
    queue_random_pixels(5);
    queue_write(wmf_pkg::CFG_IMAGE_WIDTH, 13'd2);
    queue_random_pixels(3);
    queue_write(CFG_IDX_UNUSED, 13'($urandom));
    queue_random_pixels(5);

    pixels = 0;
    while (pixels < 130) queue_random_frame(pixels);

    // Phase two: the other way round.
    queue_phase(82, 21);
    pixels = 0;
    while (pixels < 130) queue_random_frame(pixels);

    // Phase three: no idling on either side.
    queue_phase(0, 0);

    // The receiver stalls for a long stretch while a result-rich frame streams in, so the
    // block must fill up and refuse input.
    queue_setup(2'd0, 2'd1, 12'd16, 13'd8, 1'b1);
    queue_control(OP_HOLD);
    queue_random_pixels(128);

    // Image sizes above the limits: a width over the limit saturates, and a height over
    // 4096 does too. Each frame is one pixel thick in the other direction and is cut
    // short by the next register write to keep it short.
    queue_setup(2'd0, 2'd3, 12'hFFF, 13'd1, 1'b1);
    queue_random_pixels(100);
    queue_control(OP_HOLD);
    queue_random_pixels(60);
    queue_setup(2'd3, 2'd0, 12'd1, 13'h1FFF, 1'b0);
    queue_random_pixels(80);

    pixels = 0;
    while (pixels < 130) queue_random_frame(pixels);
  endtask

  // ---------------------------------------------------------------------------
  // Local model of the filter.
  // ---------------------------------------------------------------------------

  task automatic load_register(input logic [wmf_pkg::CFG_IDX_W-1:0] idx,
                               input logic [wmf_pkg::CFG_DATA_W-1:0] data);
    logic restart;
    restart = 1'b1;
    case (idx)
      wmf_pkg::CFG_RADIUS_ROWS:  rad_rows_q = data[wmf_pkg::RAD_W-1:0];
      wmf_pkg::CFG_RADIUS_COLS:  rad_cols_q = data[wmf_pkg::RAD_W-1:0];
      wmf_pkg::CFG_IMAGE_WIDTH:  width_q    = data[wmf_pkg::WIDTH_W-1:0];
      wmf_pkg::CFG_IMAGE_HEIGHT: height_q   = data[wmf_pkg::HEIGHT_W-1:0];
      wmf_pkg::CFG_COLOR_MODE:   color_q    = data[0];
      default:                   restart    = 1'b0;
    endcase
    if (restart) begin
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  // Stores the pixel in the line store and, when it completes the window of an interior
  // center, queues that window's minimum with the center left out.
  task automatic predict_window_min(input wmf_pkg::chan_t blue, input wmf_pkg::chan_t green,
                                    input wmf_pkg::chan_t red);
    int unsigned    w;
    int unsigned    h;
    int unsigned    rr;
    int unsigned    rc;
    int unsigned    rw;
    int unsigned    cl;
    int unsigned    ctr_r;
    int unsigned    ctr_c;
    logic [23:0]    sample;
    window_result_t res;
    w  = (width_q == '0) ? 1 : ((width_q > WIDTH_LIMIT) ? WIDTH_LIMIT : width_q);
    h  = (height_q == '0) ? 1 :
         ((height_q > wmf_pkg::MAX_HEIGHT) ? wmf_pkg::MAX_HEIGHT : height_q);
    rr = (rad_rows_q > RADIUS_LIMIT) ? RADIUS_LIMIT : rad_rows_q;
    rc = (rad_cols_q > RADIUS_LIMIT) ? RADIUS_LIMIT : rad_cols_q;
    rw = (row_pos >= h) ? 0 : row_pos;
    cl = (col_pos >= w) ? 0 : col_pos;

    // Gray mode keeps only the blue sample.
    line_mem[rw % RING_ROWS][cl] = color_q ? {red, green, blue} : {16'h0000, blue};

    if (rw >= 2 * rr && cl >= 2 * rc) begin
      ctr_r     = rw - rr;
      ctr_c     = cl - rc;
      res.blue  = wmf_pkg::CHAN_MAX;
      res.green = wmf_pkg::CHAN_MAX;
      res.red   = wmf_pkg::CHAN_MAX;
      for (int unsigned i = rw - 2 * rr; i <= rw; i++) begin
        for (int unsigned j = cl - 2 * rc; j <= cl; j++) begin
          if (!(i == ctr_r && j == ctr_c)) begin
            sample = line_mem[i % RING_ROWS][j];
            if (sample[7:0] < res.blue)    res.blue  = sample[7:0];
            if (sample[15:8] < res.green)  res.green = sample[15:8];
            if (sample[23:16] < res.red)   res.red   = sample[23:16];
          end
        end
      end
      if (!color_q) begin
        res.green = '0;
        res.red   = '0;
      end
      res.row       = wmf_pkg::ROW_W'(ctr_r);
      res.col       = wmf_pkg::COL_OUT_W'(ctr_c);
      res.frame_end = (rw == h - 1) && (cl == w - 1);
      expected_mins.push_back(res);
    end

    if (cl + 1 >= w) begin
      col_pos = 0;
      row_pos = (rw + 1 >= h) ? 0 : rw + 1;
    end else begin
      col_pos = cl + 1;
      row_pos = rw;
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: takes entries off the stimulus queue, one per cycle at most. A pixel refused
  // by a full block stays on the ports until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    raster_op_t op;
    logic       taken;
    logic       next_push;
    logic       next_we;
    if (rst_ni) begin
      taken     = push && !full;
      next_push = push && !taken;
      next_we   = 1'b0;
      if (!next_push && raster_ops.size() != 0) begin
        op = raster_ops[0];
        case (op.kind)
          OP_PIXEL: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              pixel_blue_i  <= op.blue;
              pixel_green_i <= op.green;
              pixel_red_i   <= op.red;
              next_push     = 1'b1;
              void'(raster_ops.pop_front());
            end
          end
          // A register write and a drain both wait until the block has gone quiet. The
          // quiet count seen here is still the value from before this edge, so an item taken at
          // this very edge also holds them back.
          OP_CONFIG: begin
            if (!taken && idle_cycles >= QUIET_CYCLES) begin
              cfg_idx_i  <= op.idx;
              cfg_data_i <= op.data;
              next_we    = 1'b1;
              void'(raster_ops.pop_front());
            end
          end
          OP_DRAIN: begin
            if (!taken && idle_cycles >= QUIET_CYCLES) void'(raster_ops.pop_front());
          end
          OP_PHASE: begin
            send_idle_pct = op.send_idle;
            recv_idle_pct <= op.recv_idle;
            void'(raster_ops.pop_front());
          end
          OP_HOLD: begin
            hold_requests <= hold_requests + 1;
            void'(raster_ops.pop_front());
          end
          default: void'(raster_ops.pop_front());
        endcase
      end
      push     <= next_push;
      cfg_we_i <= next_we;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: follows register writes and accepted pixels into the model, checks each
  // popped result, keeps the quiet count and decides pop for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic           accepted;
    window_result_t want;
    if (rst_ni) begin
      accepted = push && !full;
      if (cfg_we_i) load_register(cfg_idx_i, cfg_data_i);
      if (accepted) predict_window_min(pixel_blue_i, pixel_green_i, pixel_red_i);

      if (pop && !empty) begin
        if (expected_mins.size() == 0) begin
          $error("result with no expectation: row %0d, col %0d", out_row_o, out_col_o);
          mismatches++;
        end else begin
          want = expected_mins.pop_front();
          compare_field("min_blue",  want.blue,      min_blue_o);
          compare_field("min_green", want.green,     min_green_o);
          compare_field("min_red",   want.red,       min_red_o);
          compare_field("out_row",   want.row,       out_row_o);
          compare_field("out_col",   want.col,       out_col_o);
          compare_field("frame_end", want.frame_end, frame_end_o);
        end
      end

      if (expected_mins.size() == 0 && !accepted && !cfg_we_i) begin
        if (idle_cycles < 1000) idle_cycles <= idle_cycles + 1;
      end else begin
        idle_cycles <= 0;
      end

      // A long stall requested by the driver is counted out here, cycle by cycle.
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, run and final verdict.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    pixel_blue_i  = '0;
    pixel_green_i = '0;
    pixel_red_i   = '0;
    pop           = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    idle_cycles   = 0;
    mismatches    = 0;
    hold_left     = 0;
    holds_served  = 0;

    // Register values after reset.
    rad_rows_q = 2'd1;
    rad_cols_q = 2'd1;
    width_q    = 12'd640;
    height_q   = 13'd480;
    color_q    = 1'b1;
    row_pos    = 0;
    col_pos    = 0;

    build_stimulus();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Done once every entry has been used and the block has stayed quiet for a while
    // with nothing left to deliver.
    do @(posedge clk_i);
    while (raster_ops.size() != 0 || push || cfg_we_i || idle_cycles < END_QUIET);

    if (mismatches == 0 && expected_mins.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog for a block that hangs or never delivers an expected result.
  initial begin
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
